@@ design/dtf_pkg.sv @@
// Shared constants and types of the decimal text formatter.
// Used by every module of the block; depends on nothing.
`default_nettype none

package dtf_pkg;

    localparam int VALUE_W       = 48;
    localparam int FRACTION_BITS = 16;
    localparam int FIELD_WIDTH   = 16;
    localparam int CHAR_W        = 8;

    // magnitude times one hundred stays below 2^(VALUE_W + 6)
    localparam int PROD_W    = VALUE_W + 6;
    localparam int HUND_W    = PROD_W - FRACTION_BITS;
    localparam int STEP_BITS = 3;
    localparam int NUM_STEPS = (HUND_W + STEP_BITS - 1) / STEP_BITS;
    localparam int BIN_W     = NUM_STEPS * STEP_BITS;
    localparam int STEP_CNT_W = $clog2(NUM_STEPS + 1);
    localparam int NUM_DIGITS = (HUND_W * 1233) / 4096 + 1;
    localparam int NUM_WHOLE  = NUM_DIGITS - 2;
    localparam int FIELD_CNT_W = $clog2(FIELD_WIDTH + 1);

    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'((64'd1 << FRACTION_BITS) >> 1);

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_APOS  = 8'h27;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

    typedef logic [NUM_DIGITS-1:0][3:0] t_digits;
    typedef logic [STEP_BITS-1:0] t_carry;

    typedef struct packed {
        logic valid;
        logic neg;
    } t_conv_res;

endpackage

`default_nettype wire

@@ design/dtf_cell.sv @@
// One BCD digit cell of the binary to decimal shift chain.
// Depends on dtf_pkg; instantiated by dtf_bcd.
`default_nettype none

module dtf_cell (
    input  wire logic            i_clk,
    input  wire logic            i_clear,
    input  wire logic            i_shift,
    input  wire dtf_pkg::t_carry i_carry,
    output      dtf_pkg::t_carry o_carry,
    output      logic [3:0]      o_digit
);

    logic [3:0] r_digit;
    logic [3:0] n_digit;

    always_comb begin
        logic [3:0] v_d;
        logic [3:0] v_a;
        v_d = r_digit;
        v_a = '0;
        o_carry = '0;
        for (int s = 0; s < dtf_pkg::STEP_BITS; s++) begin
            v_a = (v_d >= 4'd5) ? v_d + 4'd3 : v_d;
            o_carry[s] = v_a[3];
            v_d = {v_a[2:0], i_carry[s]};
        end
        n_digit = v_d;
    end

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_digit <= '0;
        end else if (i_shift) begin
            r_digit <= n_digit;
        end
    end

    assign o_digit = r_digit;

endmodule

`default_nettype wire

@@ design/dtf_bcd.sv @@
// Rounding to hundredths and binary to decimal conversion over a chain of digit cells.
// Depends on dtf_pkg and dtf_cell.
`default_nettype none

module dtf_bcd (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire logic [dtf_pkg::PROD_W-1:0] i_prod,
    input  wire logic                       i_neg,
    output      logic                       o_take,
    output      dtf_pkg::t_conv_res         o_res,
    output      dtf_pkg::t_digits           o_digits,
    input  wire logic                       i_res_take
);

    logic                              r_busy;
    logic                              r_done;
    logic                              r_neg;
    logic [dtf_pkg::STEP_CNT_W-1:0]    r_cnt;
    logic [dtf_pkg::BIN_W-1:0]         r_bin;
    logic [dtf_pkg::PROD_W-1:0]        rounded;
    logic [dtf_pkg::HUND_W-1:0]        hund;
    logic [dtf_pkg::NUM_DIGITS-1:0][dtf_pkg::STEP_BITS-1:0] carry;
    dtf_pkg::t_carry                   top_carry;

    assign o_take  = i_valid && !r_busy && !r_done;
    assign rounded = i_prod + dtf_pkg::ROUND_HALF;
    assign hund    = rounded[dtf_pkg::PROD_W-1:dtf_pkg::FRACTION_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (o_take) begin
            r_busy <= 1'b1;
            r_cnt  <= dtf_pkg::STEP_CNT_W'(dtf_pkg::NUM_STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == dtf_pkg::STEP_CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else if (i_res_take) begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_bin <= dtf_pkg::BIN_W'(hund);
            r_neg <= i_neg;
        end else if (r_busy) begin
            r_bin <= r_bin << dtf_pkg::STEP_BITS;
        end
    end

    for (genvar gs = 0; gs < dtf_pkg::STEP_BITS; gs++) begin : g_feed
        assign carry[0][gs] = r_bin[dtf_pkg::BIN_W-1-gs];
    end

    for (genvar gd = 0; gd < dtf_pkg::NUM_DIGITS; gd++) begin : g_cell
        if (gd == dtf_pkg::NUM_DIGITS - 1) begin : g_top
            dtf_cell u_cell (
                .i_clk   (i_clk),
                .i_clear (o_take),
                .i_shift (r_busy),
                .i_carry (carry[gd]),
                .o_carry (top_carry),
                .o_digit (o_digits[gd])
            );
        end else begin : g_mid
            dtf_cell u_cell (
                .i_clk   (i_clk),
                .i_clear (o_take),
                .i_shift (r_busy),
                .i_carry (carry[gd]),
                .o_carry (carry[gd+1]),
                .o_digit (o_digits[gd])
            );
        end
    end

    assign o_res.valid = r_done;
    assign o_res.neg   = r_neg;

    a_busy_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_done))
        else $error("converter busy while holding a result");
    a_done_after_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_busy) && ($past(r_cnt) == dtf_pkg::STEP_CNT_W'(1)))
        else $error("result raised before all steps ran");
    a_top_no_carry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (top_carry == '0))
        else $error("digit chain overflowed its top cell");

endmodule

`default_nettype wire

@@ design/dtf_ser.sv @@
// Field layout (grouping, point, sign, padding) and character shift register.
// Depends on dtf_pkg; fed by dtf_bcd.
`default_nettype none

module dtf_ser (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire dtf_pkg::t_conv_res         i_res,
    input  wire dtf_pkg::t_digits           i_digits,
    output      logic                       o_res_take,
    output      logic                       o_valid,
    input  wire logic                       i_stall,
    output      logic [dtf_pkg::CHAR_W-1:0] o_character,
    output      logic                       o_last
);

    localparam int FW = dtf_pkg::FIELD_WIDTH;
    localparam int NW = dtf_pkg::NUM_WHOLE;

    logic [dtf_pkg::FIELD_CNT_W-1:0]            r_cnt;
    logic [FW-1:0][dtf_pkg::CHAR_W-1:0]         r_chars;
    logic [FW-1:0][dtf_pkg::CHAR_W-1:0]         n_chars;
    logic [NW:0][3:0]                           whole;
    logic [NW:0]                                nz_hi;
    logic [FW-1:0]                              pres;
    logic                                       neg;
    logic                                       pop;

    assign neg = i_res.neg && (|i_digits);

    always_comb begin
        whole[NW] = 4'd0;
        nz_hi[NW] = 1'b0;
        for (int d = NW - 1; d >= 0; d--) begin
            whole[d] = i_digits[d+2];
            nz_hi[d] = nz_hi[d+1] | (i_digits[d+2] != 4'd0);
        end
    end

    for (genvar gp = 0; gp < FW; gp++) begin : g_pos
        localparam int Q       = (gp >= 3) ? gp - 3 : 0;
        localparam bit IS_APOS = (gp >= 3) && ((Q % 4) == 3);
        localparam int DRAW    = IS_APOS ? 3 * (Q / 4 + 1) : Q - Q / 4;
        localparam int DIDX    = (DRAW < NW) ? DRAW : NW;

        logic [dtf_pkg::CHAR_W-1:0] text_ch;
        logic                       minus;

        if (gp == 0) begin : g_lo
            assign pres[gp] = 1'b1;
            assign text_ch  = dtf_pkg::CH_ZERO | {4'b0000, i_digits[0]};
            assign minus    = 1'b0;
        end else if (gp == 1) begin : g_tenth
            assign pres[gp] = 1'b1;
            assign text_ch  = dtf_pkg::CH_ZERO | {4'b0000, i_digits[1]};
            assign minus    = neg && (gp == FW - 1);
        end else if (gp == 2) begin : g_point
            assign pres[gp] = 1'b1;
            assign text_ch  = dtf_pkg::CH_POINT;
            assign minus    = neg && (gp == FW - 1);
        end else begin : g_int
            if (!IS_APOS && DRAW == 0) begin : g_unit
                assign pres[gp] = 1'b1;
            end else begin : g_upper
                assign pres[gp] = nz_hi[DIDX];
            end
            assign text_ch = IS_APOS ? dtf_pkg::CH_APOS
                                     : (dtf_pkg::CH_ZERO | {4'b0000, whole[DIDX]});
            assign minus   = neg && pres[gp-1] && ((gp == FW - 1) || !pres[gp]);
        end

        assign n_chars[FW-1-gp] = minus    ? dtf_pkg::CH_MINUS :
                                  pres[gp] ? text_ch : dtf_pkg::CH_SPACE;
    end

    assign o_valid     = (r_cnt != '0);
    assign o_last      = (r_cnt == dtf_pkg::FIELD_CNT_W'(1));
    assign o_character = r_chars[0];
    assign pop         = o_valid && !i_stall;
    assign o_res_take  = i_res.valid && (!o_valid || (pop && o_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (o_res_take) begin
            r_cnt <= dtf_pkg::FIELD_CNT_W'(FW);
        end else if (pop) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_take) begin
            r_chars <= n_chars;
        end else if (pop) begin
            for (int k = 0; k < FW - 1; k++) begin
                r_chars[k] <= r_chars[k+1];
            end
        end
    end

    a_load_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_take |=> (r_cnt == dtf_pkg::FIELD_CNT_W'(FW)))
        else $error("field load did not set the full count");
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && o_last && !i_res.valid |=> !o_valid)
        else $error("character shown after the final one with no result pending");

endmodule

`default_nettype wire

@@ design/decimal_text_formatter_unit.sv @@
// Top level of the decimal text formatter: sign and magnitude, times-100 stage,
// converter and character serializer. Depends on dtf_pkg, dtf_bcd and dtf_ser.
//
//  channel  | valid   | stall    | payload
//  ---------+---------+----------+---------------------------
//  request  | i_valid | o_stall  | i_value (48b signed)
//  char out | o_valid | i_stall  | o_character (8b), o_last
//
// Each request yields 16 characters, left to right, one per cycle while i_stall is low;
// o_last marks the final one. Sustained throughput is limited by the character serializer.
// A request passes the sign and magnitude stage, the times-100 stage, the converter load,
// 13 conversion steps of 3 bits each through the digit cells and the serializer load.
// Synchronous active-low reset clears all control flags; no clearing pass is needed.
// A stalled output holds; a full pipeline raises o_stall.
`default_nettype none

module decimal_text_formatter_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output      logic                              o_stall,
    input  wire logic signed [dtf_pkg::VALUE_W-1:0] i_value,
    output      logic                              o_valid,
    input  wire logic                              i_stall,
    output      logic [dtf_pkg::CHAR_W-1:0]        o_character,
    output      logic                              o_last
);

    logic                          r_f_valid;
    logic                          r_f_neg;
    logic [dtf_pkg::VALUE_W-1:0]   r_f_mag;
    logic                          r_m_valid;
    logic                          r_m_neg;
    logic [dtf_pkg::PROD_W-1:0]    r_m_prod;
    logic [dtf_pkg::VALUE_W-1:0]   raw;
    logic                          conv_take;
    logic                          res_take;
    logic                          m_free;
    logic                          f_free;
    logic                          in_take;
    dtf_pkg::t_conv_res            conv_res;
    dtf_pkg::t_digits              digits;

    assign raw     = i_value;
    assign m_free  = !r_m_valid || conv_take;
    assign f_free  = !r_f_valid || m_free;
    assign o_stall = !f_free;
    assign in_take = i_valid && f_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (f_free) begin
                r_f_valid <= i_valid;
            end
            if (m_free) begin
                r_m_valid <= r_f_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_f_neg <= raw[dtf_pkg::VALUE_W-1];
            r_f_mag <= raw[dtf_pkg::VALUE_W-1] ? (~raw + 1'b1) : raw;
        end
        if (m_free && r_f_valid) begin
            r_m_neg  <= r_f_neg;
            r_m_prod <= dtf_pkg::PROD_W'({r_f_mag, 6'b000000})
                      + dtf_pkg::PROD_W'({r_f_mag, 5'b00000})
                      + dtf_pkg::PROD_W'({r_f_mag, 2'b00});
        end
    end

    dtf_bcd u_bcd (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_m_valid),
        .i_prod     (r_m_prod),
        .i_neg      (r_m_neg),
        .o_take     (conv_take),
        .o_res      (conv_res),
        .o_digits   (digits),
        .i_res_take (res_take)
    );

    dtf_ser u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res       (conv_res),
        .i_digits    (digits),
        .o_res_take  (res_take),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_character (o_character),
        .o_last      (o_last)
    );

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_f_valid)
        else $error("accepted request missing from the front stage");

endmodule

`default_nettype wire

@@ tb/dtf_field_checker.sv @@
`timescale 1ns / 1ps
// Checker for the decimal text formatter. It watches both channels, predicts the character
// field of every accepted request and compares each accepted character with that prediction.
// Depends on dtf_pkg.
module dtf_field_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_req_valid,
    input  logic                               i_req_stall,
    input  logic signed [dtf_pkg::VALUE_W-1:0] i_value,
    input  logic                               i_chr_valid,
    input  logic                               i_chr_stall,
    input  logic [dtf_pkg::CHAR_W-1:0]         i_character,
    input  logic                               i_last,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import dtf_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_char_exp;

    t_char_exp field_q [$];
    t_char_exp exp_chr;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic void predict_field(input logic [VALUE_W-1:0] raw);
        logic              neg;
        logic [63:0]       mag;
        logic [63:0]       hund;
        logic [63:0]       whole;
        logic [63:0]       cents;
        logic [CHAR_W-1:0] text [64];
        logic [CHAR_W-1:0] field [FIELD_WIDTH];
        t_char_exp         e;
        int                pos;
        int                digits;
        int                keep;
        int                pad;
        int                i;
        neg = raw[VALUE_W-1];
        mag = 64'(raw);
        if (neg) begin
            mag = (64'd1 << VALUE_W) - mag;
        end
        hund = (mag * 64'd100 + ((64'd1 << FRACTION_BITS) >> 1)) >> FRACTION_BITS;
        if (hund == 64'd0) begin
            neg = 1'b0;
        end
        whole = hund / 64'd100;
        cents = hund % 64'd100;
        pos = 63;
        text[pos] = CH_ZERO + CHAR_W'(cents % 64'd10);
        pos = pos - 1;
        text[pos] = CH_ZERO + CHAR_W'(cents / 64'd10);
        pos = pos - 1;
        text[pos] = CH_POINT;
        digits = 0;
        do begin
            if (digits > 0 && digits % 3 == 0) begin
                pos = pos - 1;
                text[pos] = CH_APOS;
            end
            pos = pos - 1;
            text[pos] = CH_ZERO + CHAR_W'(whole % 64'd10);
            whole = whole / 64'd10;
            digits++;
        end while (whole != 64'd0 && pos > 1);

        keep = 64 - pos;
        if (keep > FIELD_WIDTH - int'(neg)) begin
            keep = FIELD_WIDTH - int'(neg);
        end
        pad = FIELD_WIDTH - keep - int'(neg);
        for (i = 0; i < pad; i++) begin
            field[i] = CH_SPACE;
        end
        if (neg) begin
            field[pad] = CH_MINUS;
        end
        for (i = 0; i < keep; i++) begin
            field[FIELD_WIDTH - keep + i] = text[64 - keep + i];
        end
        for (i = 0; i < FIELD_WIDTH; i++) begin
            e.code = field[i];
            e.last = (i == FIELD_WIDTH - 1);
            field_q.push_back(e);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_req_valid && !i_req_stall) begin
                predict_field(i_value);
            end
            if (i_chr_valid && !i_chr_stall) begin
                if (field_q.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("%0t: unexpected character 8'h%02h last %b",
                                 $time, i_character, i_last);
                    end
                    o_fail_count = o_fail_count + 1;
                end else begin
                    exp_chr = field_q.pop_front();
                    if (exp_chr.code !== i_character || exp_chr.last !== i_last) begin
                        if (o_fail_count < 10) begin
                            $display("%0t: character mismatch: expected 8'h%02h last %b, got 8'h%02h last %b",
                                     $time, exp_chr.code, exp_chr.last, i_character, i_last);
                        end
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            o_pending = field_q.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the decimal text formatter testbench: clock, reset, requests and output stalls
// in several idling phases, a long output hold-off, and the verdict.
// Depends on dtf_pkg, decimal_text_formatter_unit and dtf_field_checker.
module tb_top;
    import dtf_pkg::*;

    localparam int RANDOM_PER_PHASE = 50;
    localparam int HOLD_CYCLES      = 400;
    localparam int HOLD_AFTER       = 30;

    logic                      i_clk   = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic [CHAR_W-1:0]         o_character;
    logic                      o_last;

    int fail_count;
    int pending;
    int idle_pct;
    int stall_pct;
    int accepted_count;
    int hold_count;
    int phase;
    bit hold_done;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    decimal_text_formatter_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_character (o_character),
        .o_last      (o_last)
    );

    dtf_field_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_stall  (o_stall),
        .i_value      (i_value),
        .i_chr_valid  (o_valid),
        .i_chr_stall  (i_stall),
        .i_character  (o_character),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    task automatic send_request(input logic [VALUE_W-1:0] value);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        accepted_count++;
        @(negedge i_clk);
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        v = {16'($urandom), 32'($urandom)};
        case ($urandom_range(0, 9))
            0, 1, 2: ;
            3, 4, 5: v = $signed(v) >>> $urandom_range(1, 46);
            6, 7:    v = {{(VALUE_W - 20){v[VALUE_W-1]}}, v[19:0]};
            8:       v = VALUE_W'($urandom_range(0, 800)) - VALUE_W'(400);
            default: begin
                v = VALUE_W'(64'($urandom_range(0, 2000000)) * 64'd65536);
                if ($urandom_range(0, 1)) begin
                    v = -v;
                end
            end
        endcase
        return v;
    endfunction

    // hold the output once for a long stretch so the pipeline fills and stalls requests
    initial begin
        forever begin
            @(negedge i_clk);
            if (!hold_done && accepted_count >= HOLD_AFTER) begin
                hold_done = 1'b1;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) begin
                    i_stall <= 1'b1;
                    @(negedge i_clk);
                end
            end
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_request(VALUE_W'(0));
        send_request(VALUE_W'(1));
        send_request(VALUE_W'(-64'sd1));
        send_request(VALUE_W'(327));
        send_request(VALUE_W'(328));
        send_request(VALUE_W'(-64'sd327));
        send_request(VALUE_W'(-64'sd328));
        send_request(VALUE_W'(8192));
        send_request(VALUE_W'(-64'sd8192));
        send_request(VALUE_W'(65536));
        send_request(VALUE_W'(-64'sd65536));
        send_request(VALUE_W'(64'sd999 * 64'sd65536 + 64'sd65535));
        send_request(VALUE_W'(64'sd1000 * 64'sd65536));
        send_request(VALUE_W'(64'sd1000000 * 64'sd65536));
        send_request(VALUE_W'(64'sd123456789 * 64'sd65536 + 64'sd32768));
        send_request(48'h0000_FFFF_FFFF);
        send_request(48'h7FFF_FFFF_FFFF);
        send_request(48'h8000_0000_0000);
        send_request(VALUE_W'(-(64'sd1000000000 * 64'sd65536)));
        send_request(VALUE_W'(-(64'sd1234567890 * 64'sd65536 + 64'sd7864)));
        send_request(VALUE_W'(-(64'sd100000000 * 64'sd65536)));

        for (phase = 0; phase < 4; phase++) begin
            idle_pct  = (phase == 1) ? 63 : (phase == 3) ? 8 : 0;
            stall_pct = (phase == 2) ? 63 : (phase == 3) ? 8 : 0;
            repeat (RANDOM_PER_PHASE) send_request(random_value());
        end
        i_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/dtf_pkg.sv
design/dtf_cell.sv
design/dtf_bcd.sv
design/dtf_ser.sv
design/decimal_text_formatter_unit.sv
tb/dtf_field_checker.sv
tb/tb_top.sv
